[design/prmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message table package
// Shared constants, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package prmt_pkg;

   localparam int Capacity  = 64;
   localparam int SlotBits  = $clog2(Capacity);
   localparam int CountBits = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_CLAIM   = 3'd1,
      CMD_REMOVE  = 3'd2,
      CMD_RETRY   = 3'd3,
      CMD_DROP    = 3'd4,
      CMD_UNUSED5 = 3'd5,
      CMD_UNUSED6 = 3'd6,
      CMD_UNUSED7 = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ENT_PENDING  = 2'd0,
      ENT_INFLIGHT = 2'd1,
      ENT_DEAD     = 2'd2
   } entry_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ORDER,
      S_READ,
      S_EVAL,
      S_FINISH,
      S_FETCH,
      S_WRITE,
      S_RESPOND
   } fsm_type;

   typedef struct packed {
      logic [63:0] id;
      logic [7:0]  prio;
      logic [31:0] attempts;
      logic [31:0] msg_bytes;
      logic [63:0] created;
      logic [63:0] retry_at;
      logic [31:0] error;
      entry_state_type state;
   } entry_type;

endpackage

[design/prmt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message table channels
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface prmt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [63:0] msg_id;
   logic [7:0]  priority_req;
   logic [31:0] msg_bytes;
   logic signed [63:0] created_time;
   logic signed [63:0] now_time;
   logic signed [63:0] retry_time;
   logic        dead_flag;
   logic signed [31:0] error_code;
   logic        drop_policy;
   modport source (output valid, cmd, msg_id, priority_req, msg_bytes, created_time,
                   now_time, retry_time, dead_flag, error_code, drop_policy, input ready);
   modport sink (input valid, cmd, msg_id, priority_req, msg_bytes, created_time,
                 now_time, retry_time, dead_flag, error_code, drop_policy, output ready);
endinterface

interface prmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] out_id;
   logic [5:0]  out_index;
   logic [7:0]  out_priority;
   logic [31:0] out_attempts;
   logic signed [63:0] out_created;
   logic signed [63:0] out_retry_at;
   logic signed [31:0] out_error;
   logic [31:0] out_msg_bytes;
   modport source (output valid, status, out_id, out_index, out_priority, out_attempts,
                   out_created, out_retry_at, out_error, out_msg_bytes, input ready);
   modport sink (input valid, status, out_id, out_index, out_priority, out_attempts,
                 out_created, out_retry_at, out_error, out_msg_bytes, output ready);
endinterface

[design/priority_retry_message_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority retry message table
// Entry metadata in a memory, scanned one entry at a time by a sequencer.
// ----------------------------------------------------------------------------
// channel  direction  word
// req      in         command with id, priority, times, error and policy
// rsp      out        status with the chosen entry's fields
//
// Claim, remove, retry and drop scan the list one entry at a time, going through
// the order, read and evaluate states for each entry and then the finish, fetch,
// write and respond states; enqueue and unknown commands skip the scan. The next
// word is accepted in the cycle after the response word is taken.
// The scan-order memory has two read ports and the entry memory has one.
// Reset is synchronous and clears the valid bits and the entry count.
// req is not ready until the response word has been taken.
// ----------------------------------------------------------------------------
module priority_retry_message_table
   import prmt_pkg::*;
(
   input logic clock,
   input logic reset,
   prmt_req_if.sink   req,
   prmt_rsp_if.source rsp
);

   entry_type            ent_mem [Capacity];
   logic [SlotBits-1:0]  order_mem [Capacity];

   fsm_type              state_ff, state_in;
   logic [Capacity-1:0]  valid_ff;
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] pos_ff;
   logic [SlotBits-1:0]  slot_ff;
   logic [SlotBits-1:0]  order_rd_ff;
   entry_type            ent_rd_ff;
   logic                 found_ff;
   logic [SlotBits-1:0]  best_slot_ff;
   logic [CountBits-1:0] best_pos_ff;
   entry_type            best_ff;
   logic [2:0]           cmd_ff;
   logic [63:0]          id_ff;
   logic [7:0]           prio_ff;
   logic [31:0]          len_ff;
   logic [63:0]          created_ff;
   logic [63:0]          now_ff;
   logic [63:0]          retry_ff;
   logic                 dead_ff;
   logic [31:0]          error_ff;
   logic                 policy_ff;
   logic [SlotBits-1:0]  last_slot_ff;
   logic [1:0]           rsp_status_ff;

   logic                 accept;
   logic                 scan_cmd;
   logic                 at_end;
   logic                 take;
   logic                 free_found;
   logic [SlotBits-1:0]  free_slot;
   logic                 prio_gt, prio_lt, prio_eq, retry_lt, retry_eq, created_lt;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign scan_cmd = cmd_ff inside {CMD_CLAIM, CMD_REMOVE, CMD_RETRY, CMD_DROP};
   assign at_end   = (pos_ff == count_ff);

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = Capacity - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SlotBits'(i);
         end
      end
   end

   assign prio_gt    = ent_rd_ff.prio > best_ff.prio;
   assign prio_lt    = ent_rd_ff.prio < best_ff.prio;
   assign prio_eq    = ent_rd_ff.prio == best_ff.prio;
   assign retry_lt   = $signed(ent_rd_ff.retry_at) < $signed(best_ff.retry_at);
   assign retry_eq   = ent_rd_ff.retry_at == best_ff.retry_at;
   assign created_lt = $signed(ent_rd_ff.created) < $signed(best_ff.created);

   always_comb begin
      take = 1'b0;
      case (cmd_ff)
         CMD_CLAIM: begin
            if (ent_rd_ff.state == ENT_PENDING &&
                !($signed(now_ff) < $signed(ent_rd_ff.retry_at))) begin
               take = !found_ff || prio_gt ||
                      (prio_eq && (retry_lt || (retry_eq && created_lt)));
            end
         end
         CMD_DROP: begin
            if (ent_rd_ff.state == ENT_PENDING) begin
               take = !found_ff || (policy_ff ? (prio_lt || (prio_eq && created_lt))
                                              : created_lt);
            end
         end
         CMD_REMOVE, CMD_RETRY: take = !found_ff && (ent_rd_ff.id == id_ff);
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (accept) state_in = S_ORDER;
         S_ORDER:   state_in = scan_cmd ? (at_end ? S_FINISH : S_READ) : S_FINISH;
         S_READ:    state_in = S_EVAL;
         S_EVAL:    state_in = S_ORDER;
         S_FINISH:  state_in = S_FETCH;
         S_FETCH:   state_in = S_WRITE;
         S_WRITE:   state_in = S_RESPOND;
         S_RESPOND: if (rsp.ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      order_rd_ff <= order_mem[pos_ff[SlotBits-1:0]];
      ent_rd_ff   <= ent_mem[(state_ff == S_READ) ? order_rd_ff : best_slot_ff];
      last_slot_ff <= order_mem[SlotBits'(count_ff - CountBits'(1))];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff     <= req.cmd;
                  id_ff      <= req.msg_id;
                  prio_ff    <= req.priority_req;
                  len_ff     <= req.msg_bytes;
                  created_ff <= req.created_time;
                  now_ff     <= req.now_time;
                  retry_ff   <= req.retry_time;
                  dead_ff    <= req.dead_flag;
                  error_ff   <= req.error_code;
                  policy_ff  <= req.drop_policy;
                  pos_ff     <= '0;
                  found_ff   <= 1'b0;
               end
            end
            S_READ: slot_ff <= order_rd_ff;
            S_EVAL: begin
               if (take) begin
                  found_ff     <= 1'b1;
                  best_slot_ff <= slot_ff;
                  best_pos_ff  <= pos_ff;
                  best_ff      <= ent_rd_ff;
               end
               pos_ff <= pos_ff + CountBits'(1);
            end
            S_WRITE: begin
               rsp_status_ff <= STS_NOT_FOUND;
               case (cmd_ff)
                  CMD_ENQUEUE: begin
                     if (count_ff < CountBits'(Capacity) && free_found) begin
                        valid_ff[free_slot] <= 1'b1;
                        ent_mem[free_slot] <= '{id: id_ff, prio: prio_ff, attempts: '0,
                           msg_bytes: len_ff, created: created_ff, retry_at: '0,
                           error: '0, state: ENT_PENDING};
                        order_mem[count_ff[SlotBits-1:0]] <= free_slot;
                        count_ff      <= count_ff + CountBits'(1);
                        best_slot_ff  <= free_slot;
                        rsp_status_ff <= STS_OK;
                     end else begin
                        rsp_status_ff <= STS_FULL;
                     end
                  end
                  CMD_CLAIM: begin
                     if (found_ff) begin
                        best_ff.attempts <= ent_rd_ff.attempts + 32'd1;
                        best_ff.state    <= ENT_INFLIGHT;
                        ent_mem[best_slot_ff] <= '{id: ent_rd_ff.id, prio: ent_rd_ff.prio,
                           attempts: ent_rd_ff.attempts + 32'd1,
                           msg_bytes: ent_rd_ff.msg_bytes, created: ent_rd_ff.created,
                           retry_at: ent_rd_ff.retry_at, error: ent_rd_ff.error,
                           state: ENT_INFLIGHT};
                        rsp_status_ff <= STS_OK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (found_ff) begin
                        valid_ff[best_slot_ff] <= 1'b0;
                        order_mem[best_pos_ff[SlotBits-1:0]] <= last_slot_ff;
                        count_ff      <= count_ff - CountBits'(1);
                        rsp_status_ff <= STS_OK;
                     end
                  end
                  CMD_RETRY: begin
                     if (found_ff) begin
                        ent_mem[best_slot_ff] <= '{id: ent_rd_ff.id, prio: ent_rd_ff.prio,
                           attempts: ent_rd_ff.attempts,
                           msg_bytes: ent_rd_ff.msg_bytes, created: ent_rd_ff.created,
                           retry_at: dead_ff ? 64'd0 : retry_ff, error: error_ff,
                           state: dead_ff ? ENT_DEAD : ENT_PENDING};
                        rsp_status_ff <= STS_OK;
                     end
                  end
                  CMD_DROP: if (found_ff) rsp_status_ff <= STS_OK;
                  default: rsp_status_ff <= STS_NOT_FOUND;
               endcase
            end
            default: ;
         endcase
      end
   end

   logic ok, full_fields;
   assign ok          = (state_ff == S_RESPOND) && (rsp_status_ff == STS_OK);
   assign full_fields = ok && (cmd_ff == CMD_CLAIM);

   assign rsp.valid         = (state_ff == S_RESPOND);
   assign rsp.status        = rsp_status_ff;
   assign rsp.out_id        = (ok && (cmd_ff inside {CMD_CLAIM, CMD_DROP})) ?
                              best_ff.id : 64'd0;
   assign rsp.out_index     = ok ? 6'(best_slot_ff) : 6'd0;
   assign rsp.out_priority  = full_fields ? best_ff.prio : 8'd0;
   assign rsp.out_attempts  = full_fields ? best_ff.attempts : 32'd0;
   assign rsp.out_created   = full_fields ? best_ff.created : 64'd0;
   assign rsp.out_retry_at  = full_fields ? best_ff.retry_at : 64'd0;
   assign rsp.out_error     = full_fields ? best_ff.error : 32'd0;
   assign rsp.out_msg_bytes = full_fields ? best_ff.msg_bytes : 32'd0;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(Capacity)) else $error("entry count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == int'(count_ff)))
      else $error("valid bits disagree with entry count");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("request taken while response pending");

endmodule
